// ===== design/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer and unmasker.
`default_nettype none

package wsd_pkg;

    // Widest accumulated message length
    localparam int unsigned LENGTH_BITS = 16;
    localparam logic [16:0] LEN_MAX     = 17'((64'd1 << LENGTH_BITS) - 64'd1);

    // Decoupling queue between parser and output stage
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Header byte fields
    localparam logic [7:0] RSV_MASK    = 8'h70;
    localparam logic [7:0] FIN_MASK    = 8'h80;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_RESERVED,
        ERR_OPCODE,
        ERR_UNMASKED,
        ERR_LEN64,
        ERR_SIZE
    } err_t;

    // One queued result: raw byte and key byte are combined in the output stage
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        is_text;
        logic        eom;
        logic [15:0] length;
        err_t        code;
    } wsd_item_t;

endpackage

`default_nettype wire

// ===== design/wsd_queue.sv =====
// Small register FIFO that decouples the header parser from the output stage.
`default_nettype none

module wsd_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wsd_pkg::wsd_item_t push_item,
    output logic              full,
    input  wire               pop,
    output wsd_pkg::wsd_item_t pop_item,
    output logic              empty
);
    import wsd_pkg::*;

    wsd_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + QCNT_W'($past(do_push))
                              - QCNT_W'($past(do_pop)))
        else $error("queue count out of step with push and pop");

endmodule

`default_nettype wire

// ===== design/wsd_parser.sv =====
// Front end: header parser, size checks and message bookkeeping, one byte per cycle while in_accept is high.
`default_nettype none

module wsd_parser (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_accept,
    input  wire  [7:0]         in_byte,
    input  wire  [15:0]        limit,
    output logic               push,
    output wsd_pkg::wsd_item_t push_item
);
    import wsd_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic        fin_reg,    fin_next;
    logic        text_reg,   text_next;
    logic [31:0] key_reg,    key_next;
    logic [15:0] rem_reg,    rem_next;
    logic [1:0]  hidx_reg,   hidx_next;
    logic [1:0]  kpos_reg,   kpos_next;
    logic [15:0] count_reg,  count_next;
    logic        dead_reg,   dead_next;

    logic [15:0] len;
    logic [16:0] sum;
    logic        too_big;
    logic [15:0] ext_len;
    logic [7:0]  key_byte;
    logic [15:0] count_inc;
    logic [15:0] rem_dec;

    assign ext_len   = {rem_reg[7:0], in_byte};
    assign len       = (phase_reg == PH_EXT) ? ext_len : {9'd0, in_byte[6:0]};
    assign sum       = {1'b0, count_reg} + {1'b0, len};
    assign too_big   = (sum > {1'b0, limit}) || (sum > LEN_MAX);
    assign count_inc = count_reg + 16'd1;
    assign rem_dec   = rem_reg - 16'd1;

    always_comb
    begin
        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        fin_next   = fin_reg;
        text_next  = text_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        hidx_next  = hidx_reg;
        kpos_next  = kpos_reg;
        count_next = count_reg;
        dead_next  = dead_reg;

        push              = 1'b0;
        push_item.kind    = KIND_ERROR;
        push_item.raw_byte = 8'd0;
        push_item.key_byte = 8'd0;
        push_item.is_text = text_reg;
        push_item.eom     = 1'b0;
        push_item.length  = count_reg;
        push_item.code    = ERR_RESERVED;

        if (in_accept && !dead_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next = |(in_byte & FIN_MASK);
                    if ((in_byte & RSV_MASK) != 8'd0)
                    begin
                        push           = 1'b1;
                        push_item.code = ERR_RESERVED;
                        dead_next      = 1'b1;
                    end
                    else
                    begin
                        unique case (in_byte[3:0])
                            OP_CONT:
                            begin
                                phase_next = PH_HDR1;
                            end
                            OP_TEXT, OP_BINARY:
                            begin
                                text_next  = (in_byte[3:0] == OP_TEXT);
                                count_next = 16'd0;
                                phase_next = PH_HDR1;
                            end
                            default:
                            begin
                                push           = 1'b1;
                                push_item.code = ERR_OPCODE;
                                dead_next      = 1'b1;
                            end
                        endcase
                    end
                end
                PH_HDR1:
                begin
                    if ((in_byte & MASK_BIT) == 8'd0)
                    begin
                        push           = 1'b1;
                        push_item.code = ERR_UNMASKED;
                        dead_next      = 1'b1;
                    end
                    else if (in_byte[6:0] == LEN_EXT64)
                    begin
                        push           = 1'b1;
                        push_item.code = ERR_LEN64;
                        dead_next      = 1'b1;
                    end
                    else if (in_byte[6:0] == LEN_EXT16)
                    begin
                        phase_next = PH_EXT;
                        hidx_next  = 2'd0;
                        rem_next   = 16'd0;
                    end
                    else if (too_big)
                    begin
                        push           = 1'b1;
                        push_item.code = ERR_SIZE;
                        dead_next      = 1'b1;
                    end
                    else
                    begin
                        rem_next   = len;
                        phase_next = PH_KEY;
                        hidx_next  = 2'd0;
                    end
                end
                PH_EXT:
                begin
                    rem_next = ext_len;
                    if (hidx_reg == 2'd0)
                    begin
                        hidx_next = 2'd1;
                    end
                    else if (too_big)
                    begin
                        push           = 1'b1;
                        push_item.code = ERR_SIZE;
                        dead_next      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_KEY;
                        hidx_next  = 2'd0;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    if (hidx_reg != 2'd3)
                    begin
                        hidx_next = hidx_reg + 2'd1;
                    end
                    else
                    begin
                        hidx_next = 2'd0;
                        kpos_next = 2'd0;
                        if (rem_reg == 16'd0)
                        begin
                            phase_next = PH_HDR0;
                            if (fin_reg)
                            begin
                                push           = 1'b1;
                                push_item.kind = KIND_END;
                                push_item.eom  = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    kpos_next          = kpos_reg + 2'd1;
                    count_next         = count_inc;
                    rem_next           = rem_dec;
                    push               = 1'b1;
                    push_item.kind     = KIND_DATA;
                    push_item.raw_byte = in_byte;
                    push_item.key_byte = key_byte;
                    push_item.length   = count_inc;
                    if (rem_dec == 16'd0)
                    begin
                        phase_next    = PH_HDR0;
                        push_item.eom = fin_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            fin_reg   <= 1'b0;
            text_reg  <= 1'b0;
            key_reg   <= '0;
            rem_reg   <= '0;
            hidx_reg  <= '0;
            kpos_reg  <= '0;
            count_reg <= '0;
            dead_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            text_reg  <= text_next;
            key_reg   <= key_next;
            rem_reg   <= rem_next;
            hidx_reg  <= hidx_next;
            kpos_reg  <= kpos_next;
            count_reg <= count_next;
            dead_reg  <= dead_next;
        end
    end

    a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |=> dead_reg)
        else $error("parser left the dead state without reset");

    a_error_kills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.kind == KIND_ERROR) |=> dead_reg)
        else $error("error item queued without stopping the parser");

    a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |-> !push)
        else $error("item queued after an error");

endmodule

`default_nettype wire

// ===== design/wsd_emit.sv =====
// Back end: unmask the payload byte and hold the result in the output register.
`default_nettype none

module wsd_emit (
    input  wire                clk,
    input  wire                rst_n,
    input  wsd_pkg::wsd_item_t q_item,
    input  wire                q_empty,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);
    import wsd_pkg::*;

    logic        valid_reg;
    kind_t       kind_reg;
    logic [7:0]  payload_reg;
    logic        text_reg;
    logic        eom_reg;
    logic [15:0] length_reg;
    err_t        code_reg;

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg    <= q_item.kind;
            payload_reg <= (q_item.kind == KIND_DATA) ? (q_item.raw_byte ^ q_item.key_byte)
                                                     : 8'd0;
            text_reg    <= q_item.is_text;
            eom_reg     <= q_item.eom;
            length_reg  <= q_item.length;
            code_reg    <= q_item.code;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, code_reg, length_reg, text_reg, payload_reg};
    assign m_tlast  = eom_reg;
    assign m_tuser  = kind_reg;

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg != KIND_DATA) |-> payload_reg == 8'd0)
        else $error("non-data item carries payload bits");

endmodule

`default_nettype wire

// ===== design/websocket_frame_deframer_unmasker_core.sv =====
// Top level of the WebSocket client frame deframer and unmasker.
// The item for a byte accepted at one edge is written into the queue at that same edge
//   and loaded from the queue into the output register, which raises m_tvalid, once
//   the output register is free.
// Throughput: one byte per cycle while s_tready is high; the parser updates its state per byte.
// s_tready drops only when the four-item queue is full, so output stalls do not
//   block input until the queue fills.
// Reset (rst_n, async, active low) clears parser state and queue; message_limit = 32768.
`default_nettype none

module websocket_frame_deframer_unmasker_core (
    input  wire         clk,
    input  wire         rst_n,
    // Configuration write: message_limit
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] stream_byte
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_out, [8] is_text,
                                   // [24:9] message_length, [27:25] error_code, rest 0
    output logic        m_tlast,   // end_of_message
    output logic [1:0]  m_tuser    // kind
);
    import wsd_pkg::*;

    logic [15:0] limit_reg;
    logic        in_accept;
    logic        push;
    wsd_item_t   push_item;
    wsd_item_t   pop_item;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    // The user writes configuration only while idle; the block does not enforce this, as cfg_ready is tied high.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 16'd32768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Every accepted byte queues at most one item, so a free slot is enough.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    // Front: parse headers, track lengths, queue results.
    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .limit     (limit_reg),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: lets the parser run on while the output side stalls.
    wsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // Back: unmask and drive the result stream.
    wsd_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (pop_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_full) |-> 1'b0)
        else $error("parser queued an item into a full queue");

endmodule

`default_nettype wire

// ===== tb/wsd_frame_checker.sv =====
// Scoreboard for the WebSocket deframer: predicts every result from the accepted bytes and checks it.
module wsd_frame_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [15:0] cfg_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,
    input  wire         m_tlast,
    input  wire  [1:0]  m_tuser,
    output int          mismatches,
    output int          results_checked,
    output int          results_due_count
);
    import wsd_pkg::*;

    // Error field reads zero on payload and end items
    localparam err_t NO_ERROR = ERR_RESERVED;
    localparam int   MAX_REPORTS = 20;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        text;
        logic        eom;
        logic [15:0] length;
        err_t        code;
    } deframed_t;

    deframed_t   results_due[$];
    deframed_t   want;

    // Parser copy
    logic [15:0] limit_reg;
    phase_t      hdr_state;
    logic        final_frame;
    logic        text_msg;
    logic [31:0] key_word;
    logic [15:0] bytes_left;
    logic [1:0]  hdr_step;
    logic [1:0]  key_slot;
    logic [15:0] msg_len;
    logic        locked_out;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("wsd_frame_checker: %s mismatch on result %0d: got 0x%0h, want 0x%0h",
                     what, results_checked, got, exp_val);
    endtask

    task automatic queue_result(input kind_t k, input logic [7:0] d, input logic eom,
                                input err_t c);
        deframed_t r;
        r.kind   = k;
        r.data   = d;
        r.text   = text_msg;
        r.eom    = eom;
        r.length = msg_len;
        r.code   = c;
        results_due.push_back(r);
    endtask

    task automatic raise_error(input err_t c);
        locked_out = 1'b1;
        queue_result(KIND_ERROR, 8'h00, 1'b0, c);
    endtask

    // Frame length known: the whole message must stay within the limit and the counter width
    task automatic check_length(input logic [15:0] len);
        logic [16:0] total;
        total = {1'b0, msg_len} + {1'b0, len};
        if (total > {1'b0, limit_reg} || total > LEN_MAX)
            raise_error(ERR_SIZE);
        else
        begin
            bytes_left = len;
            hdr_state  = PH_KEY;
            hdr_step   = 2'd0;
        end
    endtask

    task automatic unmask_byte(input logic [7:0] b);
        logic [7:0] clear;
        if (locked_out)
            return;
        case (hdr_state)
            PH_HDR1:
                if ((b & MASK_BIT) == 8'h00)
                    raise_error(ERR_UNMASKED);
                else if (b[6:0] == LEN_EXT64)
                    raise_error(ERR_LEN64);
                else if (b[6:0] == LEN_EXT16)
                begin
                    hdr_state  = PH_EXT;
                    hdr_step   = 2'd0;
                    bytes_left = 16'd0;
                end
                else
                    check_length({9'd0, b[6:0]});
            PH_EXT:
            begin
                bytes_left = {bytes_left[7:0], b};
                if (hdr_step == 2'd0)
                    hdr_step = 2'd1;
                else
                    check_length(bytes_left);
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], b};
                if (hdr_step < 2'd3)
                    hdr_step = hdr_step + 2'd1;
                else
                begin
                    hdr_step = 2'd0;
                    key_slot = 2'd0;
                    if (bytes_left == 16'd0)
                    begin
                        hdr_state = PH_HDR0;
                        if (final_frame)
                            queue_result(KIND_END, 8'h00, 1'b1, NO_ERROR);
                    end
                    else
                        hdr_state = PH_DATA;
                end
            end
            PH_DATA:
            begin
                clear      = b ^ key_word[8 * (3 - int'(key_slot)) +: 8];
                key_slot   = key_slot + 2'd1;
                msg_len    = msg_len + 16'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                begin
                    hdr_state = PH_HDR0;
                    queue_result(KIND_DATA, clear, final_frame, NO_ERROR);
                end
                else
                    queue_result(KIND_DATA, clear, 1'b0, NO_ERROR);
            end
            default:
            begin
                final_frame = (b & FIN_MASK) != 8'h00;
                if ((b & RSV_MASK) != 8'h00)
                    raise_error(ERR_RESERVED);
                else
                begin
                    case (b[3:0])
                        OP_CONT: ;
                        OP_TEXT, OP_BINARY:
                        begin
                            text_msg = (b[3:0] == OP_TEXT);
                            msg_len  = 16'd0;
                        end
                        default: raise_error(ERR_OPCODE);
                    endcase
                    if (!locked_out)
                        hdr_state = PH_HDR1;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg         = 16'd32768;
            hdr_state         = PH_HDR0;
            final_frame       = 1'b0;
            text_msg          = 1'b0;
            key_word          = 32'd0;
            bytes_left        = 16'd0;
            hdr_step          = 2'd0;
            key_slot          = 2'd0;
            msg_len           = 16'd0;
            locked_out        = 1'b0;
            mismatches        = 0;
            results_checked   = 0;
            results_due.delete();
            results_due_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (results_due.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 32'h0);
                else
                begin
                    want = results_due.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("kind", m_tuser, want.kind);
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("payload", m_tdata[7:0], want.data);
                    if (m_tdata[8] != want.text)
                        report_mismatch("is_text", m_tdata[8], want.text);
                    if (m_tdata[24:9] != want.length)
                        report_mismatch("message_length", m_tdata[24:9], want.length);
                    if (m_tdata[27:25] != want.code)
                        report_mismatch("error_code", m_tdata[27:25], want.code);
                    if (m_tdata[31:28] != 4'h0)
                        report_mismatch("tdata padding", m_tdata[31:28], 32'h0);
                    if (m_tlast != want.eom)
                        report_mismatch("end_of_message", m_tlast, want.eom);
                end
            end
            if (s_tvalid && s_tready)
                unmask_byte(s_tdata);
            results_due_count <= results_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the WebSocket deframer: byte stream, limit writes, backpressure and verdict.
module tb_top;
    import wsd_pkg::*;

    // Cycles the receiver holds off in one stretch; far longer than the four-item queue
    localparam int LONG_HOLD = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    wire         cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    wire         s_tready;
    logic [7:0]  s_tdata;
    wire         m_tvalid;
    logic        m_tready;
    wire  [31:0] m_tdata;
    wire         m_tlast;
    wire  [1:0]  m_tuser;

    int mismatches;
    int results_checked;
    int results_due_count;

    // Idle rates in percent, and requests for a long receiver hold-off
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asked  = 0;

    int          bytes_sent = 0;
    logic [15:0] cur_limit  = 16'd32768;
    // Running message count as the block sees it; keeps random frames under the limit
    int          msg_bytes  = 0;
    logic [15:0] last_limit;
    err_t        closing_error;

    // Opening sequence, one frame after the other:
    //   empty non-final text frame (no result),
    //   final continuation of two bytes that unmask to 0xff,
    //   final binary frame with a 16-bit length of 1 (non-minimal encoding),
    //   empty final continuation outside any message (stray end that keeps the count).
    logic [7:0] opening_bytes [29] = '{
        {4'h0, OP_TEXT}, 8'h80, 8'h00, 8'hff, 8'h00, 8'hff,
        FIN_MASK | {4'h0, OP_CONT}, 8'h82, 8'hff, 8'h00, 8'ha5, 8'h5a, 8'h00, 8'hff,
        FIN_MASK | {4'h0, OP_BINARY}, MASK_BIT | {1'b0, LEN_EXT16}, 8'h00, 8'h01,
        8'h12, 8'h34, 8'h56, 8'h78, 8'h6b,
        FIN_MASK | {4'h0, OP_CONT}, 8'h80, 8'h5a, 8'ha5, 8'h0f, 8'hf0
    };

    always #5 clk = ~clk;

    websocket_frame_deframer_unmasker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] stream_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] payload_out, [8] is_text, [24:9] message_length,
                                 // [27:25] error_code, rest 0
        .m_tlast   (m_tlast),    // end_of_message
        .m_tuser   (m_tuser)     // kind
    );

    wsd_frame_checker frame_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .mismatches        (mismatches),
        .results_checked   (results_checked),
        .results_due_count (results_due_count)
    );

    // Receiver: draw tready each cycle from the idle rate; on a new hold request,
    // drop tready for a long stretch counted here so the queue fills behind it.
    initial
    begin : receiver
        int hold_left;
        int holds_started;
        hold_left     = 0;
        holds_started = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_started != hold_asked)
            begin
                holds_started = hold_asked;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stop a hung run; far beyond the slowest correct run
    initial
    begin : watchdog
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Offer one byte and hold it until accepted; then maybe idle for a short gap.
    // Every call starts and ends on a rising edge.
    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    // Wait for every predicted result, then idle before touching
    // the limit register.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    // Masked frame with a random key and payload; long_form picks the 16-bit length
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic [15:0] len,
                              input logic long_form);
        send_byte({fin, 3'b000, op});
        if (long_form)
        begin
            send_byte(MASK_BIT | {1'b0, LEN_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else
            send_byte(MASK_BIT | {1'b0, len[6:0]});
        repeat (4) send_byte(8'($urandom));
        repeat (len) send_byte(8'($urandom));
        msg_bytes += int'(len);
    endtask

    // Mostly short frames, some empty, a few past the 7-bit length; clip to the room left
    function automatic int pick_length();
        int room;
        int r;
        int len;
        room = (int'(cur_limit) > msg_bytes) ? int'(cur_limit) - msg_bytes : 0;
        r    = $urandom_range(99);
        if (r < 10)
            len = 0;
        else if (r < 85)
            len = $urandom_range(8, 1);
        else if (r < 97)
            len = $urandom_range(40, 9);
        else
            len = $urandom_range(200, 126);
        return (len > room) ? room : len;
    endfunction

    // One message of one to three frames, now and then followed by a stray continuation
    task automatic send_message();
        int         frames;
        int         len;
        logic [3:0] op;
        frames    = $urandom_range(3, 1);
        op        = $urandom_range(1) ? OP_TEXT : OP_BINARY;
        msg_bytes = 0;
        for (int k = 0; k < frames; k++)
        begin
            len = pick_length();
            send_frame(k == frames - 1, (k == 0) ? op : OP_CONT, 16'(len),
                       len > 125 || $urandom_range(9) == 0);
        end
        // A stray continuation still checks count plus length, so skip it once over the limit
        if ($urandom_range(7) == 0 && msg_bytes <= int'(cur_limit))
        begin
            len = pick_length();
            send_frame(1'($urandom_range(1)), OP_CONT, 16'(len), len > 125);
        end
    endtask

    task automatic send_messages_until(input int byte_total);
        while (bytes_sent < byte_total)
            send_message();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 16'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Sender idles lightly, receiver heavily; limit at its reset value
        tx_idle_pct = 20;
        rx_idle_pct = 63;
        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        // The binary frame set the count to one; the stray end kept it
        msg_bytes = 1;
        send_messages_until(200);
        drain_results();

        // Top limit, idling swapped; long frames fit here
        write_limit(16'hffff);
        tx_idle_pct = 63;
        rx_idle_pct = 20;
        send_messages_until(330);
        drain_results();

        // Limit zero: only empty frames get through, final ones still end the message
        write_limit(16'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_messages_until(380);
        drain_results();

        // Limit one: every message holds a single byte at most
        write_limit(16'd1);
        send_messages_until(420);
        drain_results();

        // Random small limit at full rate; stall the receiver long while bytes keep coming
        last_limit = 16'($urandom_range(400, 40));
        write_limit(last_limit);
        hold_asked++;
        send_messages_until(530);
        drain_results();

        // Close with one protocol error; the block stays dead, so it comes last.
        // Reserved bits come with any opcode and an unmasked header with any length
        // code, so the precedence of the checks gets exercised too.
        closing_error = err_t'($urandom_range(int'(ERR_SIZE)));
        case (closing_error)
            ERR_RESERVED:
                send_byte({1'($urandom_range(1)), 3'($urandom_range(7, 1)), 4'($urandom)});
            ERR_OPCODE:
                send_byte({1'($urandom_range(1)), 3'b000, 4'($urandom_range(15, 3))});
            ERR_UNMASKED:
            begin
                send_byte(FIN_MASK | {4'h0, OP_TEXT});
                send_byte({1'b0, 7'($urandom)});
            end
            ERR_LEN64:
            begin
                send_byte(FIN_MASK | {4'h0, OP_BINARY});
                send_byte(MASK_BIT | {1'b0, LEN_EXT64});
            end
            default:
            begin
                // Frame one past the limit or more, announced with the 16-bit length
                cfg_data <= cfg_data;
                send_byte(FIN_MASK | {4'h0, OP_BINARY});
                send_byte(MASK_BIT | {1'b0, LEN_EXT16});
                send_byte(8'((int'(last_limit) + 40) >> 8));
                send_byte(8'(int'(last_limit) + $urandom_range(40, 1)));
            end
        endcase
        // Feed noise into the dead block; nothing may come out
        repeat (12) send_byte(8'($urandom));
        drain_results();
        repeat (20) @(posedge clk);

        $display("tb_top: %0d stream bytes sent, %0d results checked, %0d mismatches",
                 bytes_sent, results_checked, mismatches);
        $display("tb_top: limits 32768, 65535, 0, 1 and %0d covered; closed by %s",
                 last_limit, closing_error.name());
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
